/* design/lbcp_pkg.sv */
// Shared types and constants for the lidar beam to Cartesian point block.
`timescale 1ns / 1ps

package lbcp_pkg;

  // CORDIC datapath widths: x and y carry 30 fraction bits, z is a 32-bit phase residual
  localparam int CW = 34;
  localparam int ZW = 32;
  localparam int NCELL = 20;
  localparam logic signed [CW-1:0] GAIN_INIT = 34'sd652032874;

  // sine and cosine with 15 fraction bits, range [-1.0, +1.0]
  localparam int TW = 17;

  localparam int OUT_W = 22;
  localparam int OUT_LIMIT = 1100000;

  // configuration port
  localparam int CFG_IDX_W = 4;
  localparam int CFG_W = 21;
  localparam logic [CFG_IDX_W-1:0] CFG_START_ANGLE = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_STEP = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_RANGE = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RANGE = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_POSE_X = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_POSE_Y = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_POSE_HEADING = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_MODE = 4'd7;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
  } rot_t;

  // one cell's worth of work: the beam angle and the pose heading side by side
  typedef struct packed {
    rot_t beam;
    rot_t head;
  } lane_t;

endpackage

/* design/lidar_beam_to_cartesian_point.sv */
// Lidar beam to Cartesian point: top level with config registers and the CORDIC cell chain.
//
// Usage: drive a beam (range_mm, range_not_number, beam_index) with start high; it is
// taken at the clock edge where start is high and busy is low. busy is low except
// during reset, so one beam can be taken every cycle, back to back.
// A beam that is flagged not-a-number or whose range lies outside
// [min_range_mm, max_range_mm] gives no point. Any other beam gives one point:
// point_valid is high for exactly one cycle with point_x_mm, point_y_mm and
// point_beam. Points leave in the order the beams came in. The receiver cannot
// stall; a point must be taken in the cycle it is shown.
// Throughput is one beam per cycle outside reset. A beam passes through one input
// stage, one quadrant split stage, the 20-cell CORDIC chain that resolves the beam
// angle and the pose heading together, one sine/cosine rounding stage, two multiply
// stages and the output stage.
// Configuration: write register cfg_index with cfg_data on a cfg_valid/cfg_ready
// transfer; cfg_ready is always high. Write only while no beam is in flight.
// Reset (rst, synchronous) empties the pipeline and loads the register defaults:
// all zero except max_range_mm = 65535.
`timescale 1ns / 1ps

module lidar_beam_to_cartesian_point import lbcp_pkg::*; #(
  parameter int ANGLE_BITS = 16,
  parameter int RANGE_BITS = 16,
  parameter int INDEX_BITS = 12
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [RANGE_BITS-1:0]       range_mm,
  input  logic                        range_not_number,
  input  logic [INDEX_BITS-1:0]       beam_index,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_W-1:0]            cfg_data,
  output logic                        point_valid,
  output logic signed [OUT_W-1:0]     point_x_mm,
  output logic signed [OUT_W-1:0]     point_y_mm,
  output logic [INDEX_BITS-1:0]       point_beam
);

  localparam int PROD_W = INDEX_BITS + 17;
  localparam int RCMP_W = (RANGE_BITS > 16) ? RANGE_BITS : 16;
  localparam int TAG_W = 4 + RANGE_BITS + INDEX_BITS;
  localparam int PR_W = RANGE_BITS + 18;
  localparam int XS_W = RANGE_BITS + 2;
  localparam int PW = XS_W + TW;
  localparam int SUM_W = XS_W + 19;
  localparam int LAT = NCELL + 5;

  typedef struct packed {
    logic [1:0] q;
    rot_t       rot;
  } prep_t;

  // configuration registers
  logic [15:0]          start_angle;
  logic [15:0]          angle_step;
  logic [15:0]          min_range_mm;
  logic [15:0]          max_range_mm;
  logic signed [20:0]   pose_x_mm;
  logic signed [20:0]   pose_y_mm;
  logic [15:0]          pose_heading;
  logic                 map_mode;

  assign cfg_ready = 1'b1;
  assign busy = rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_angle <= '0;
      angle_step <= '0;
      min_range_mm <= '0;
      max_range_mm <= 16'hFFFF;
      pose_x_mm <= '0;
      pose_y_mm <= '0;
      pose_heading <= '0;
      map_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_START_ANGLE:  start_angle <= cfg_data[15:0];
        CFG_ANGLE_STEP:   angle_step <= cfg_data[15:0];
        CFG_MIN_RANGE:    min_range_mm <= cfg_data[15:0];
        CFG_MAX_RANGE:    max_range_mm <= cfg_data[15:0];
        CFG_POSE_X:       pose_x_mm <= cfg_data;
        CFG_POSE_Y:       pose_y_mm <= cfg_data;
        CFG_POSE_HEADING: pose_heading <= cfg_data[15:0];
        CFG_MAP_MODE:     map_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // ---------------- input stage: range gate and beam angle ----------------
  logic                   accept;
  logic                   keep;
  logic [PROD_W-1:0]      angle_sum;
  logic                   v_a;
  logic [ANGLE_BITS-1:0]  angle_a;
  logic [RANGE_BITS-1:0]  r_a;
  logic [INDEX_BITS-1:0]  idx_a;

  assign accept = start && !busy;
  assign keep = !range_not_number
             && (RCMP_W'(range_mm) >= RCMP_W'(min_range_mm))
             && (RCMP_W'(range_mm) <= RCMP_W'(max_range_mm));
  assign angle_sum = PROD_W'(beam_index) * PROD_W'(angle_step) + PROD_W'(start_angle);

  always_ff @(posedge clk) begin
    if (rst) begin
      v_a <= 1'b0;
    end else begin
      v_a <= accept && keep;
    end
  end

  always_ff @(posedge clk) begin
    angle_a <= ANGLE_BITS'(angle_sum);
    r_a <= range_mm;
    idx_a <= beam_index;
  end

  // ---------------- quadrant split feeding the cell chain ----------------
  // nearest quarter turn goes to q, residual in [-1/8, 1/8) turn seeds z
  function automatic prep_t prep(input logic [ANGLE_BITS-1:0] ang);
    prep_t p;
    logic [31:0] phase;
    logic [31:0] ph2;
    logic [31:0] d;
    phase = {ang, {(32 - ANGLE_BITS){1'b0}}};
    ph2 = phase + 32'h2000_0000;
    p.q = ph2[31:30];
    d = phase - {p.q, 30'd0};
    p.rot.x = GAIN_INIT;
    p.rot.y = '0;
    p.rot.z = $signed(d);
    return p;
  endfunction

  prep_t pb;
  prep_t ph;
  assign pb = prep(angle_a);
  assign ph = prep(ANGLE_BITS'(pose_heading));

  localparam int IDX_LO = 0;
  localparam int R_LO = INDEX_BITS;
  localparam int QB_LO = INDEX_BITS + RANGE_BITS;
  localparam int QH_LO = QB_LO + 2;

  lane_t            lane [0:NCELL];
  logic [TAG_W-1:0] tag  [0:NCELL];
  logic             vld  [0:NCELL];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= v_a;
    end
  end

  always_ff @(posedge clk) begin
    lane[0].beam <= pb.rot;
    lane[0].head <= ph.rot;
    tag[0] <= {ph.q, pb.q, r_a, idx_a};
  end

  for (genvar g = 0; g < NCELL; g++) begin : g_cell
    lbcp_cordic_cell #(
      .STAGE (g),
      .TAG_W (TAG_W)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (vld[g]),
      .in_lane   (lane[g]),
      .in_tag    (tag[g]),
      .out_valid (vld[g+1]),
      .out_lane  (lane[g+1]),
      .out_tag   (tag[g+1])
    );
  end

  // ---------------- quadrant rotate, round to Q1.15, clamp ----------------
  function automatic logic signed [TW-1:0] round15(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] t;
    logic signed [TW-1:0] o;
    t = (v + $signed(CW'(16384))) >>> 15;
    if (t > $signed(CW'(32768))) begin
      o = TW'(32768);
    end else if (t < $signed(CW'(-32768))) begin
      o = TW'(-32768);
    end else begin
      o = TW'(t);
    end
    return o;
  endfunction

  function automatic logic [2*TW-1:0] cos_sin(input rot_t a, input logic [1:0] q);
    logic signed [CW-1:0] c;
    logic signed [CW-1:0] s;
    case (q)
      2'd0: begin
        c = a.x;
        s = a.y;
      end
      2'd1: begin
        c = -a.y;
        s = a.x;
      end
      2'd2: begin
        c = -a.x;
        s = -a.y;
      end
      default: begin
        c = a.y;
        s = -a.x;
      end
    endcase
    return {round15(c), round15(s)};
  endfunction

  logic [2*TW-1:0]        cs_b;
  logic [2*TW-1:0]        cs_h;
  logic                   v_d;
  logic signed [TW-1:0]   c_d;
  logic signed [TW-1:0]   s_d;
  logic signed [TW-1:0]   ch_d;
  logic signed [TW-1:0]   sh_d;
  logic [RANGE_BITS-1:0]  r_d;
  logic [INDEX_BITS-1:0]  idx_d;

  assign cs_b = cos_sin(lane[NCELL].beam, tag[NCELL][QB_LO +: 2]);
  assign cs_h = cos_sin(lane[NCELL].head, tag[NCELL][QH_LO +: 2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      v_d <= 1'b0;
    end else begin
      v_d <= vld[NCELL];
    end
  end

  always_ff @(posedge clk) begin
    c_d <= $signed(cs_b[2*TW-1:TW]);
    s_d <= $signed(cs_b[TW-1:0]);
    ch_d <= $signed(cs_h[2*TW-1:TW]);
    sh_d <= $signed(cs_h[TW-1:0]);
    r_d <= tag[NCELL][R_LO +: RANGE_BITS];
    idx_d <= tag[NCELL][IDX_LO +: INDEX_BITS];
  end

  // ---------------- sensor frame point ----------------
  logic signed [PR_W-1:0] prx;
  logic signed [PR_W-1:0] pry;
  logic                   v_e;
  logic signed [XS_W-1:0] xs_e;
  logic signed [XS_W-1:0] ys_e;
  logic signed [TW-1:0]   ch_e;
  logic signed [TW-1:0]   sh_e;
  logic [INDEX_BITS-1:0]  idx_e;

  assign prx = PR_W'($signed({1'b0, r_d})) * PR_W'(c_d);
  assign pry = PR_W'($signed({1'b0, r_d})) * PR_W'(s_d);

  always_ff @(posedge clk) begin
    if (rst) begin
      v_e <= 1'b0;
    end else begin
      v_e <= v_d;
    end
  end

  always_ff @(posedge clk) begin
    xs_e <= XS_W'((prx + $signed(PR_W'(16384))) >>> 15);
    ys_e <= XS_W'((pry + $signed(PR_W'(16384))) >>> 15);
    ch_e <= ch_d;
    sh_e <= sh_d;
    idx_e <= idx_d;
  end

  // ---------------- pose rotation products ----------------
  logic                   v_f;
  logic signed [PW-1:0]   p_xc;
  logic signed [PW-1:0]   p_ys;
  logic signed [PW-1:0]   p_xs;
  logic signed [PW-1:0]   p_yc;
  logic signed [XS_W-1:0] xs_f;
  logic signed [XS_W-1:0] ys_f;
  logic [INDEX_BITS-1:0]  idx_f;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_f <= 1'b0;
    end else begin
      v_f <= v_e;
    end
  end

  always_ff @(posedge clk) begin
    p_xc <= PW'(xs_e) * PW'(ch_e);
    p_ys <= PW'(ys_e) * PW'(sh_e);
    p_xs <= PW'(xs_e) * PW'(sh_e);
    p_yc <= PW'(ys_e) * PW'(ch_e);
    xs_f <= xs_e;
    ys_f <= ys_e;
    idx_f <= idx_e;
  end

  // ---------------- offset, mode select, saturate ----------------
  function automatic logic signed [OUT_W-1:0] sat(input logic signed [SUM_W-1:0] v);
    logic signed [OUT_W-1:0] o;
    if (v > $signed(SUM_W'(OUT_LIMIT))) begin
      o = OUT_W'(OUT_LIMIT);
    end else if (v < $signed(SUM_W'(-OUT_LIMIT))) begin
      o = OUT_W'(-OUT_LIMIT);
    end else begin
      o = OUT_W'(v);
    end
    return o;
  endfunction

  logic signed [SUM_W-1:0] rx;
  logic signed [SUM_W-1:0] ry;
  logic signed [SUM_W-1:0] mx;
  logic signed [SUM_W-1:0] my;
  logic signed [SUM_W-1:0] sel_x;
  logic signed [SUM_W-1:0] sel_y;

  assign rx = SUM_W'(p_xc) - SUM_W'(p_ys) + $signed(SUM_W'(16384));
  assign ry = SUM_W'(p_xs) + SUM_W'(p_yc) + $signed(SUM_W'(16384));
  assign mx = (rx >>> 15) + SUM_W'(pose_x_mm);
  assign my = (ry >>> 15) + SUM_W'(pose_y_mm);
  assign sel_x = map_mode ? mx : SUM_W'(xs_f);
  assign sel_y = map_mode ? my : SUM_W'(ys_f);

  always_ff @(posedge clk) begin
    if (rst) begin
      point_valid <= 1'b0;
    end else begin
      point_valid <= v_f;
    end
  end

  always_ff @(posedge clk) begin
    point_x_mm <= sat(sel_x);
    point_y_mm <= sat(sel_y);
    point_beam <= idx_f;
  end

  // ---------------- assertions ----------------
  a_reset_flush: assert property (@(posedge clk) rst |=> !point_valid)
    else $error("point strobe after reset");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    point_valid |-> ($past(v_a, LAT) && (point_beam == $past(idx_a, LAT))))
    else $error("point without matching kept beam");

  a_drop_nan: assert property (@(posedge clk) disable iff (rst)
    $past(start && !busy && range_not_number, LAT + 1) |-> !point_valid)
    else $error("not-a-number beam produced a point");

  a_sat: assert property (@(posedge clk) disable iff (rst)
    point_valid |-> ((point_x_mm <= 22'sd1100000) && (point_x_mm >= -22'sd1100000)
                  && (point_y_mm <= 22'sd1100000) && (point_y_mm >= -22'sd1100000)))
    else $error("point outside saturation limits");

endmodule

/* design/lbcp_cordic_cell.sv */
// One rotation-mode CORDIC cell: a fixed micro-rotation on both lanes plus a tag.
`timescale 1ns / 1ps

module lbcp_cordic_cell import lbcp_pkg::*; #(
  parameter int STAGE = 0,
  parameter int TAG_W = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  lane_t            in_lane,
  input  logic [TAG_W-1:0] in_tag,
  output logic             out_valid,
  output lane_t            out_lane,
  output logic [TAG_W-1:0] out_tag
);

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic signed [ZW-1:0] atan_at(input int i);
    logic signed [ZW-1:0] a;
    case (i)
      0:       a = 32'sd536870912;
      1:       a = 32'sd316933406;
      2:       a = 32'sd167458907;
      3:       a = 32'sd85004756;
      4:       a = 32'sd42667331;
      5:       a = 32'sd21354465;
      6:       a = 32'sd10679838;
      7:       a = 32'sd5340245;
      8:       a = 32'sd2670163;
      9:       a = 32'sd1335087;
      10:      a = 32'sd667544;
      11:      a = 32'sd333772;
      12:      a = 32'sd166886;
      13:      a = 32'sd83443;
      14:      a = 32'sd41722;
      15:      a = 32'sd20861;
      16:      a = 32'sd10430;
      17:      a = 32'sd5215;
      18:      a = 32'sd2608;
      19:      a = 32'sd1304;
      default: a = '0;
    endcase
    return a;
  endfunction

  localparam logic signed [ZW-1:0] ANG = atan_at(STAGE);

  function automatic rot_t micro(input rot_t a);
    rot_t r;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    dx = a.y >>> STAGE;
    dy = a.x >>> STAGE;
    if (!a.z[ZW-1]) begin
      r.x = a.x - dx;
      r.y = a.y + dy;
      r.z = a.z - ANG;
    end else begin
      r.x = a.x + dx;
      r.y = a.y - dy;
      r.z = a.z + ANG;
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_lane.beam <= micro(in_lane.beam);
    out_lane.head <= micro(in_lane.head);
    out_tag <= in_tag;
  end

endmodule
